[rtl/core/gbm_path_extrema_stepper_macros.svh]
// ------------------------------------------------------------------------
// GBM stepper assertion macros
// Shared property forms for the port checker.
// ------------------------------------------------------------------------
`ifndef GBM_PATH_EXTREMA_STEPPER_MACROS_SVH
`define GBM_PATH_EXTREMA_STEPPER_MACROS_SVH

// same-cycle implication
`define GBM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gbm_pkg.sv]
// ------------------------------------------------------------------------
// GBM stepper package
// Constants, register indexes and reciprocal table for the path stepper.
// ------------------------------------------------------------------------
package gbm_pkg;

  localparam int STEP_BITS_DEF = 20;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int MUL_W         = 34;
  localparam int DIV_N_W       = 64;
  localparam int DIV_D_W       = 35;
  localparam int TAYLOR_TERMS  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPOT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BGK_ENABLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BGK_FACTOR     = 3'd5;

  localparam logic [31:0] RST_INITIAL_SPOT = 32'd6553600;
  localparam logic [31:0] RST_BGK_FACTOR   = 32'd1073741824;
  localparam int          RST_NUM_STEPS    = 1000;

  localparam logic [31:0]        SAT32     = 32'hFFFF_FFFF;
  localparam logic [DIV_D_W-1:0] LN2_Q29   = 35'd372130559;
  localparam logic [MUL_W-1:0]   LN2_MUL   = 34'd372130559;
  // floor(2^43 / ln2 in Q29); applied to the offset exponent over 8, scaled by 2^40
  localparam logic [MUL_W-1:0]   K_RECIP   = 34'd23637;
  localparam logic signed [39:0] X_LIMIT   = 40'sd8589934592;
  localparam logic signed [39:0] K_OFFSET  = 40'sd8931133416;
  localparam logic [5:0]         K_BIAS_SH = 6'd54;
  localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;

  function automatic logic [32:0] recip(input logic [3:0] n);
    logic [32:0] m;
    case (n)
      4'd1:    m = 33'd4294967296;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      4'd11:   m = 33'd390451572;
      4'd12:   m = 33'd357913941;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/gbm_if.sv]
// ------------------------------------------------------------------------
// GBM stepper channels
// Valid/ready channels for the sample input and the path result.
// ------------------------------------------------------------------------
interface gbm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_sample;
  modport source (output valid, output normal_sample, input ready);
  modport sink (input valid, input normal_sample, output ready);
endinterface

interface gbm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] final_spot;
  logic [31:0] max_spot;
  logic [31:0] min_spot;
  modport source (output valid, output final_spot, output max_spot, output min_spot,
                  input ready);
  modport sink (input valid, input final_spot, input max_spot, input min_spot,
                output ready);
endinterface

[rtl/core/gbm_mul.sv]
// ------------------------------------------------------------------------
// GBM shared multiplier
// Signed multiplier with a registered product, shared by every step phase.
// ------------------------------------------------------------------------
module gbm_mul
  import gbm_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

[rtl/core/gbm_div.sv]
// ------------------------------------------------------------------------
// GBM iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
module gbm_div
  import gbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done_r,
  output logic [DIV_N_W-1:0] quot_r
);

  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   dsr_r;
  logic [6:0]           cnt_r;
  logic                 busy_r;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  assign trial = {rem_r, quot_r[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quot_r <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= fits ? DIV_D_W'(trial - {1'b0, dsr_r}) : trial[DIV_D_W-1:0];
        quot_r <= {quot_r[DIV_N_W-2:0], fits};
        cnt_r  <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/gbm_path_extrema_stepper.sv]
// ------------------------------------------------------------------------
// GBM path stepper with running extremes
// Steps the spot by exp(drift + diffusion * sample), tracks max and min,
// and emits one result per path.
// ------------------------------------------------------------------------
// A sample is taken only in the idle state, so a new sample cannot transfer until the
// last one has run its full step; the 12-term series, each term a multiply, a reciprocal
// multiply and a rounding fix on the shared multiplier, dominates it. A path end adds a
// load of the result; with correction it adds the max multiply first, and with a nonzero
// factor also a wait on the divider. A result still held downstream stalls the next path end.
// Synchronous reset loads the register defaults and clears the step count.
module gbm_path_extrema_stepper
  import gbm_pkg::*;
#(
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gbm_in_if.sink               in_chan,
  gbm_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_XMUL, S_XADD, S_KMUL, S_KEST, S_KREM, S_TMUL, S_TREC, S_TCOR,
    S_SMUL, S_SSH, S_BMUL, S_BHI, S_LDIV, S_EMIT
  } state_t;

  state_t               state_r;
  logic [31:0]          init_r, drift_r, diff_r, factor_r;
  logic [STEP_BITS-1:0] nsteps_r, step_r;
  logic                 bgk_r;
  logic signed [15:0]   sample_r;
  logic [31:0]          spot_r, hi_r, lo_r, hic_r, loc_r;
  logic [5:0]           k_r;
  logic [34:0]          xoff_r;
  logic [29:0]          r30_r;
  logic [30:0]          term_r, v_r;
  logic [31:0]          sum_r;
  logic [3:0]           n_r;
  logic                 out_valid_r;
  logic [31:0]          fin_o_r, max_o_r, min_o_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] p_r;
  logic                      div_start, div_done;
  logic [DIV_N_W-1:0]        div_n, quot;
  logic [DIV_D_W-1:0]        div_d;

  logic signed [39:0] xsum, xcl, xoff;
  logic [34:0]        kdiff, kred;
  logic               kfix;
  logic [30:0]        q0, tnew;
  logic [34:0]        qn, rdiff;
  logic [5:0]         shamt;
  logic [63:0]        pshift;
  logic [31:0]        spot_new, hi_new, lo_new, hi_corr, lo_q;
  logic               path_end;

  gbm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));

  gbm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done_r(div_done), .quot_r(quot)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_XMUL: begin
        mul_a = {{2{diff_r[31]}}, diff_r};
        mul_b = {{18{sample_r[15]}}, sample_r};
      end
      S_KMUL: begin
        mul_a = {2'b0, xoff_r[34:3]};
        mul_b = K_RECIP;
      end
      S_KEST: begin
        mul_a = {28'b0, p_r[45:40]};
        mul_b = LN2_MUL;
      end
      S_TMUL: begin
        mul_a = {3'b0, term_r};
        mul_b = {4'b0, r30_r};
      end
      S_TREC: begin
        mul_a = {3'b0, p_r[60:30]};
        mul_b = {1'b0, recip(n_r)};
      end
      S_SMUL: begin
        mul_a = {2'b0, spot_r};
        mul_b = {2'b0, sum_r};
      end
      S_BMUL: begin
        mul_a = {2'b0, hi_r};
        mul_b = {2'b0, factor_r};
      end
      default: ;
    endcase
  end

  assign xsum = {{8{drift_r[31]}}, drift_r} + {{4{p_r[47]}}, p_r[47:12]};
  assign xcl  = (xsum > X_LIMIT) ? X_LIMIT : ((xsum < -X_LIMIT) ? -X_LIMIT : xsum);
  assign xoff = xcl + K_OFFSET;

  assign kdiff = xoff_r - p_r[34:0];
  assign kfix  = kdiff >= LN2_Q29;
  assign kred  = kfix ? kdiff - LN2_Q29 : kdiff;

  assign div_start = (state_r == S_BHI) && (factor_r != '0);
  assign div_n = {2'b0, lo_r, 30'b0};
  assign div_d = {3'b0, factor_r};

  assign q0    = p_r[62:32];
  assign qn    = 35'(q0 * n_r);
  assign rdiff = {4'b0, v_r} - qn;
  assign tnew  = (rdiff >= {31'b0, n_r}) ? q0 + 31'd1 : q0;

  assign shamt    = K_BIAS_SH - k_r;
  assign pshift   = p_r[63:0] >> shamt;
  assign spot_new = (pshift[63:32] != '0) ? SAT32 : pshift[31:0];
  assign hi_new   = (spot_new > hi_r) ? spot_new : hi_r;
  assign lo_new   = (spot_new < lo_r) ? spot_new : lo_r;
  assign path_end = ({1'b0, step_r} + 1'b1) >= {1'b0, nsteps_r};
  assign hi_corr  = (p_r[63:62] != '0) ? SAT32 : p_r[61:30];
  assign lo_q     = (quot[63:32] != '0) ? SAT32 : quot[31:0];

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.final_spot = fin_o_r;
  assign out_chan.max_spot   = max_o_r;
  assign out_chan.min_spot   = min_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      init_r      <= RST_INITIAL_SPOT;
      drift_r     <= '0;
      diff_r      <= '0;
      nsteps_r    <= STEP_BITS'(RST_NUM_STEPS);
      bgk_r       <= 1'b0;
      factor_r    <= RST_BGK_FACTOR;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_SPOT:   init_r   <= cfg_data;
          CFG_DRIFT_STEP:     drift_r  <= cfg_data;
          CFG_DIFFUSION_STEP: diff_r   <= cfg_data;
          CFG_NUM_STEPS:      nsteps_r <= cfg_data[STEP_BITS-1:0];
          CFG_BGK_ENABLE:     bgk_r    <= cfg_data[0];
          CFG_BGK_FACTOR:     factor_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_chan.ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            sample_r <= in_chan.normal_sample;
            if (step_r == '0) begin
              spot_r <= init_r;
              hi_r   <= init_r;
              lo_r   <= init_r;
            end
            state_r <= S_XMUL;
          end
        end
        S_XMUL: state_r <= S_XADD;
        S_XADD: begin
          xoff_r  <= xoff[34:0];
          state_r <= S_KMUL;
        end
        S_KMUL: state_r <= S_KEST;
        S_KEST: begin
          k_r     <= p_r[45:40];
          state_r <= S_KREM;
        end
        S_KREM: begin
          k_r     <= kfix ? k_r + 6'd1 : k_r;
          r30_r   <= {kred[28:0], 1'b0};
          term_r  <= ONE_Q30;
          sum_r   <= {1'b0, ONE_Q30};
          n_r     <= 4'd1;
          state_r <= S_TMUL;
        end
        S_TMUL: state_r <= S_TREC;
        S_TREC: begin
          v_r     <= p_r[60:30];
          state_r <= S_TCOR;
        end
        S_TCOR: begin
          term_r <= tnew;
          sum_r  <= sum_r + {1'b0, tnew};
          n_r    <= n_r + 4'd1;
          state_r <= (n_r == 4'(TAYLOR_TERMS)) ? S_SMUL : S_TMUL;
        end
        S_SMUL: state_r <= S_SSH;
        S_SSH: begin
          spot_r <= spot_new;
          hi_r   <= hi_new;
          lo_r   <= lo_new;
          if (path_end) begin
            hic_r   <= hi_new;
            loc_r   <= lo_new;
            state_r <= bgk_r ? S_BMUL : S_EMIT;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_BMUL: state_r <= S_BHI;
        S_BHI: begin
          hic_r <= hi_corr;
          if (factor_r == '0) begin
            loc_r   <= (lo_r == '0) ? '0 : SAT32;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_done) begin
            loc_r   <= lo_q;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            fin_o_r     <= spot_r;
            max_o_r     <= hic_r;
            min_o_r     <= loc_r;
            out_valid_r <= 1'b1;
            step_r      <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/gbm_chk.sv]
// ------------------------------------------------------------------------
// GBM stepper port checker
// Port-level properties of the stepper, bound to the top level.
// ------------------------------------------------------------------------
`include "gbm_path_extrema_stepper_macros.svh"

module gbm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] final_spot
);

  `GBM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready held after transfer")
  `GBM_ASSERT_SAME(a_emit_busy, $rose(out_valid), !$past(in_ready), "result raised while idle")
  `GBM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `GBM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(final_spot), "result changed")

endmodule

bind gbm_path_extrema_stepper gbm_chk u_gbm_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_chan.valid), .in_ready(in_chan.ready),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .final_spot(out_chan.final_spot)
);
